/* hdl/rfme_pkg.sv */
package rfme_pkg;

   localparam int SYMBOL_W = 10;
   localparam int BITS_W   = 4;
   localparam int STEP_W   = 4;

   localparam logic [BITS_W-1:0] SYNC_BITS  = 4'd3;
   localparam logic [BITS_W-1:0] FRAME_BITS = 4'd10;
   localparam logic [SYMBOL_W-1:0] SYNC_GROUP = 10'h001;

   localparam logic [7:0] HEADER0 = 8'h33;
   localparam logic [7:0] HEADER1 = 8'h55;
   localparam logic [7:0] HEADER2 = 8'h53;
   localparam logic [7:0] FOOTER0 = 8'h35;
   localparam logic [7:0] FOOTER1 = 8'h55;
   localparam logic [7:0] FOOTER2 = 8'h55;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // group sequence of one item; an item walks a contiguous slice of it
   localparam logic [STEP_W-1:0] STEP_SYNC  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_HEAD0 = 4'd1;
   localparam logic [STEP_W-1:0] STEP_HEAD1 = 4'd2;
   localparam logic [STEP_W-1:0] STEP_HEAD2 = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HI    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LO    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_FOOT0 = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FOOT1 = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FOOT2 = 4'd8;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [7:0]        coded;
      logic [STEP_W-1:0] step;
   } item_type;

   // 0, b0..b7, 1 with the first bit on top
   function automatic logic [SYMBOL_W-1:0] plain_frame(input logic [7:0] v);
      logic [SYMBOL_W-1:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s[8-i] = v[i];
      end
      s[0] = 1'b1;
      return s;
   endfunction

   function automatic logic [SYMBOL_W-1:0] nibble_frame(input logic [3:0] n);
      logic [SYMBOL_W-1:0] s;
      s = '0;
      for (int i = 0; i < 4; i++) begin
         s[8-2*i] = n[i];
         s[7-2*i] = ~n[i];
      end
      s[0] = 1'b1;
      return s;
   endfunction

endpackage

/* hdl/rfme_channels.sv */
interface rfme_req_if import rfme_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface rfme_rsp_if import rfme_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic [BITS_W-1:0]   symbol_bits;
   logic                last;

   modport source (output valid, output symbol, output symbol_bits, output last,
                   input ready);
   modport sink   (input valid, input symbol, input symbol_bits, input last,
                   output ready);
endinterface

/* hdl/rfme_item_stage.sv */
module rfme_item_stage import rfme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       in_kind,
   input  logic [7:0] in_data,
   input  logic       take,
   output item_type   item
);

   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [7:0]        coded_ff, coded_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              in_message_ff, in_message_in;
   logic [7:0]        sum_ff, sum_in;
   logic [STEP_W-1:0] end_step;
   logic              done;
   logic              accept;

   assign end_step = (kind_ff == KIND_END) ? STEP_FOOT2 : STEP_LO;
   assign done     = take && valid_ff && (step_ff == end_step);
   assign in_ready = !valid_ff || done;
   assign accept   = in_valid && in_ready;

   always_comb begin
      valid_in      = valid_ff;
      kind_in       = kind_ff;
      coded_in      = coded_ff;
      step_in       = step_ff;
      in_message_in = in_message_ff;
      sum_in        = sum_ff;
      if (done) begin
         valid_in = 1'b0;
      end else if (take && valid_ff) begin
         step_in = step_ff + 4'd1;
      end
      if (accept) begin
         valid_in = 1'b1;
         kind_in  = in_kind;
         step_in  = in_message_ff ? STEP_HI : STEP_SYNC;
         if (in_kind == KIND_DATA) begin
            coded_in      = in_data;
            sum_in        = sum_ff + in_data;
            in_message_in = 1'b1;
         end else begin
            coded_in      = 8'd0 - sum_ff;
            sum_in        = 8'd0;
            in_message_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         in_message_ff <= 1'b0;
         sum_ff        <= 8'd0;
         step_ff       <= STEP_SYNC;
      end else begin
         valid_ff      <= valid_in;
         in_message_ff <= in_message_in;
         sum_ff        <= sum_in;
         step_ff       <= step_in;
      end
      kind_ff  <= kind_in;
      coded_ff <= coded_in;
   end

   assign item.valid = valid_ff;
   assign item.kind  = kind_ff;
   assign item.coded = coded_ff;
   assign item.step  = step_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> step_ff <= STEP_FOOT2)
      else $error("group step beyond footer");

   a_data_stops_at_lo: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == KIND_DATA) |-> step_ff <= STEP_LO)
      else $error("data item ran past its low nibble");

   a_outside_message_sum: assert property (@(posedge clock) disable iff (reset)
      !in_message_ff |-> sum_ff == 8'd0)
      else $error("running sum not cleared outside a message");

   a_mid_message_no_sync: assert property (@(posedge clock) disable iff (reset)
      accept && in_message_ff |=> step_ff == STEP_HI)
      else $error("preamble sent inside a message");

endmodule

/* hdl/rfme_group_out.sv */
module rfme_group_out import rfme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   output logic       take,
   rfme_rsp_if.source rsp_if
);

   logic                out_valid_ff, out_valid_in;
   logic [SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic                last_ff, last_in;
   logic                advance;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign take    = advance && item.valid;

   always_comb begin
      out_valid_in = out_valid_ff;
      symbol_in    = symbol_ff;
      bits_in      = bits_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = item.valid;
         bits_in      = FRAME_BITS;
         last_in      = (item.step == STEP_FOOT2);
         case (item.step)
            STEP_SYNC: begin
               symbol_in = SYNC_GROUP;
               bits_in   = SYNC_BITS;
            end
            STEP_HEAD0: symbol_in = plain_frame(HEADER0);
            STEP_HEAD1: symbol_in = plain_frame(HEADER1);
            STEP_HEAD2: symbol_in = plain_frame(HEADER2);
            STEP_HI:    symbol_in = nibble_frame(item.coded[7:4]);
            STEP_LO:    symbol_in = nibble_frame(4'(item.coded & NIBBLE_MASK));
            STEP_FOOT0: symbol_in = plain_frame(FOOTER0);
            STEP_FOOT1: symbol_in = plain_frame(FOOTER1);
            STEP_FOOT2: symbol_in = plain_frame(FOOTER2);
            default:    symbol_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      symbol_ff <= symbol_in;
      bits_ff   <= bits_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.symbol      = symbol_ff;
   assign rsp_if.symbol_bits = bits_ff;
   assign rsp_if.last        = last_ff;

   a_last_is_frame: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && last_ff |-> bits_ff == FRAME_BITS)
      else $error("last marked on a sync group");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("group taken from item but not presented");

endmodule

/* hdl/radio_frame_manchester_encoder.sv */
// The first group of an item passes the item register, then the output register.
// Throughput: one group per cycle from the output register while the sink is ready;
// a data byte is 2 groups, the first byte of a message 6, an end item 5, an empty message 9.
// The next item is accepted in the cycle its predecessor's final group is loaded.
// Reset clears the message flag, running sum, pending item and output valid.
module radio_frame_manchester_encoder import rfme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rfme_req_if.sink   req_if,
   rfme_rsp_if.source rsp_if
);

   item_type item;
   logic     take;

   rfme_item_stage u_item (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_kind  (req_if.kind),
      .in_data  (req_if.data_byte),
      .take     (take),
      .item     (item)
   );

   rfme_group_out u_out (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .take   (take),
      .rsp_if (rsp_if)
   );

endmodule
